[rtl/spq_pkg.sv]
// Shared definitions for the sorted priority queue.
// Holds operation codes, result status codes, the cell control struct and
// default sizes. Depends on nothing else.
package spq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_KEY_BITS    = 16;
   localparam int DEF_TAG_BITS    = 16;

   localparam int OCC_BITS   = 5;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_POP    = 1'b1
   } spq_func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } spq_status_type;

   // Broadcast to every cell in the cycle a beat is accepted.
   typedef struct packed {
      logic insert;
      logic pop;
   } spq_ctl_type;

endpackage

[rtl/spq_cell.sv]
// One slot of the sorted queue: holds a key and a tag and shifts with its
// neighbors on insert (toward the tail) or pop (toward the head).
// Depends on spq_pkg.
module spq_cell #(
   parameter int KEY_BITS = spq_pkg::DEF_KEY_BITS,
   parameter int TAG_BITS = spq_pkg::DEF_TAG_BITS
) (
   input  logic                       clock,
   input  spq_pkg::spq_ctl_type       ctl,
   input  logic                       occupied,
   input  logic signed [KEY_BITS-1:0] new_key,
   input  logic        [TAG_BITS-1:0] new_tag,
   input  logic                       prev_after,
   input  logic signed [KEY_BITS-1:0] prev_key,
   input  logic        [TAG_BITS-1:0] prev_tag,
   input  logic signed [KEY_BITS-1:0] next_key,
   input  logic        [TAG_BITS-1:0] next_tag,
   output logic                       after,
   output logic signed [KEY_BITS-1:0] key,
   output logic        [TAG_BITS-1:0] tag
);

   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic        [TAG_BITS-1:0] tag_ff, tag_in;

   // The new entry lands behind this slot only if this slot holds a
   // strictly larger priority; equal priorities are overtaken.
   assign after = occupied && (new_key < key_ff);

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (ctl.insert && !after) begin
         key_in = prev_after ? new_key : prev_key;
         tag_in = prev_after ? new_tag : prev_tag;
      end else if (ctl.pop) begin
         key_in = next_key;
         tag_in = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key = key_ff;
   assign tag = tag_ff;

endmodule

[rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: a chain of spq_cell slots plus
// the entry count and the registered result stage.
// Depends on spq_pkg and spq_cell.
//
// Usage: every request beat carries func (insert or pop), a signed
// priority and a payload tag. Each request produces exactly one response
// beat with a status, the popped payload and priority (zero unless a pop
// succeeded) and the occupancy after the operation.
// Slot 0 always holds the highest priority; among equal priorities the
// most recently inserted entry is served first. An insert into a full
// queue is dropped with status FULL; a pop of an empty queue returns
// status EMPTY. Neither changes the contents.
// The response beat is registered and appears in the cycle after its request is accepted.
// Throughput is one request per cycle while req_stall is low: all slots compare against the new
// key in parallel and shift with their neighbor in the same cycle.
// The response register is the only buffer; while the receiver stalls a
// pending response, req_stall is raised and the response holds steady.
// Reset empties the queue and clears the response valid.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
   parameter int KEY_BITS    = spq_pkg::DEF_KEY_BITS,
   parameter int TAG_BITS    = spq_pkg::DEF_TAG_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [15:0] req_priority_req,
   input  logic [15:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_payload,
   output logic [15:0] rsp_out_priority,
   output logic [4:0]  rsp_occupancy
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                       accept;
   logic                       is_pop;
   logic                       full;
   logic                       empty;
   logic [31:0]                pri_wide;
   logic [31:0]                tag_wide;
   logic signed [KEY_BITS-1:0] new_key;
   logic        [TAG_BITS-1:0] new_tag;
   spq_pkg::spq_ctl_type       ctl;

   logic [CW-1:0] count_ff, count_in;

   logic                       after_w [QUEUE_DEPTH];
   logic signed [KEY_BITS-1:0] key_w   [QUEUE_DEPTH];
   logic        [TAG_BITS-1:0] tag_w   [QUEUE_DEPTH];

   logic                         rsp_valid_ff, rsp_valid_in;
   spq_pkg::spq_status_type      status_ff, status_in;
   logic [15:0]                  opay_ff, opay_in;
   logic [15:0]                  oprio_ff, oprio_in;
   logic [spq_pkg::OCC_BITS-1:0] occ_ff, occ_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_pop    = (spq_pkg::spq_func_type'(req_func) == spq_pkg::FUNC_POP);
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   // Bits above KEY_BITS / TAG_BITS are ignored; the key is signed in its
   // own width.
   assign pri_wide = 32'(req_priority_req);
   assign tag_wide = 32'(req_payload);
   assign new_key  = signed'(pri_wide[KEY_BITS-1:0]);
   assign new_tag  = tag_wide[TAG_BITS-1:0];

   assign ctl = '{insert: accept && !is_pop && !full,
                  pop:    accept && is_pop && !empty};

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                       occ;
      logic                       p_after;
      logic signed [KEY_BITS-1:0] p_key;
      logic        [TAG_BITS-1:0] p_tag;
      logic signed [KEY_BITS-1:0] n_key;
      logic        [TAG_BITS-1:0] n_tag;

      assign occ = (count_ff > CW'(i));

      if (i == 0) begin : g_head
         // The head takes the new entry directly unless it stays put.
         assign p_after = 1'b0;
         assign p_key   = new_key;
         assign p_tag   = new_tag;
      end else begin : g_body
         assign p_after = after_w[i-1];
         assign p_key   = key_w[i-1];
         assign p_tag   = tag_w[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign n_key = key_w[i];
         assign n_tag = tag_w[i];
      end else begin : g_inner
         assign n_key = key_w[i+1];
         assign n_tag = tag_w[i+1];
      end

      spq_cell #(
         .KEY_BITS (KEY_BITS),
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (occ),
         .new_key    (new_key),
         .new_tag    (new_tag),
         .prev_after (p_after),
         .prev_key   (p_key),
         .prev_tag   (p_tag),
         .next_key   (n_key),
         .next_tag   (n_tag),
         .after      (after_w[i]),
         .key        (key_w[i]),
         .tag        (tag_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      logic [31:0] key_ext;
      logic [31:0] tag_ext;
      logic [31:0] cnt_ext;
      key_ext   = 32'(key_w[0]);
      tag_ext   = 32'(tag_w[0]);
      cnt_ext   = 32'(count_in);
      status_in = spq_pkg::STATUS_OK;
      opay_in   = '0;
      oprio_in  = '0;
      if (is_pop) begin
         if (empty) begin
            status_in = spq_pkg::STATUS_EMPTY;
         end else begin
            opay_in  = tag_ext[15:0];
            oprio_in = key_ext[15:0];
         end
      end else if (full) begin
         status_in = spq_pkg::STATUS_FULL;
      end
      occ_in = cnt_ext[spq_pkg::OCC_BITS-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         opay_ff   <= opay_in;
         oprio_ff  <= oprio_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_payload  = opay_ff;
   assign rsp_out_priority = oprio_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

[rtl/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to its top level.
// Depends on spq_pkg and on sorted_priority_queue for the bind.
module spq_checker #(
   parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_out_payload,
   input logic [15:0] rsp_out_priority,
   input logic [4:0]  rsp_occupancy
);

   localparam logic [4:0] FULL_OCC = 5'(QUEUE_DEPTH);

   // A stalled response beat must stay valid and hold its status, payload and occupancy.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_payload) && $stable(rsp_occupancy))
      else $error("stalled response beat changed");

   // Every accepted request yields a response beat in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // A failed pop reports an empty queue and no data.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::STATUS_EMPTY |->
         rsp_occupancy == 5'd0 && rsp_out_payload == 16'd0
         && rsp_out_priority == 16'd0)
      else $error("empty status with data or nonzero occupancy");

   // A dropped insert reports a full queue.
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::STATUS_FULL |->
         rsp_occupancy == FULL_OCC && rsp_out_payload == 16'd0)
      else $error("full status with wrong occupancy");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sorted_priority_queue spq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_out_payload  (rsp_out_payload),
   .rsp_out_priority (rsp_out_priority),
   .rsp_occupancy    (rsp_occupancy)
);

[verif/sorted_priority_queue_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: random and directed inserts and pops
// are checked beat by beat against a shadow copy of the sorted queue.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_tb;

   localparam int DEPTH    = spq_pkg::DEF_QUEUE_DEPTH;
   localparam int WATCHDOG = 4000;

   typedef struct packed {
      spq_pkg::spq_status_type      status;
      logic [15:0]                  tag;
      logic [15:0]                  key;
      logic [spq_pkg::OCC_BITS-1:0] occupancy;
   } queue_outcome_type;

   class spq_scoreboard;
      logic signed [15:0] shadow_keys[DEPTH];
      logic [15:0]        shadow_tags[DEPTH];
      int                 held;
      queue_outcome_type  pending_outcomes[$];
      int                 errors;
      int                 requests;
      int                 served_pops;
      int                 full_drops;
      int                 empty_pops;
      int                 peak_held;

      function new();
         held        = 0;
         errors      = 0;
         requests    = 0;
         served_pops = 0;
         full_drops  = 0;
         empty_pops  = 0;
         peak_held   = 0;
      endfunction

      function int outstanding();
         return pending_outcomes.size();
      endfunction

      task report(input string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Apply one accepted request to the shadow queue and queue up its outcome.
      function void note_request(input spq_pkg::spq_func_type func,
                                 input logic [15:0] key, input logic [15:0] tag);
         queue_outcome_type res;
         int pos;
         res = '{status: spq_pkg::STATUS_OK, tag: '0, key: '0, occupancy: '0};
         requests++;
         if (func == spq_pkg::FUNC_INSERT) begin
            if (held >= DEPTH) begin
               res.status = spq_pkg::STATUS_FULL;
               full_drops++;
            end else begin
               pos = 0;
               // A new entry goes ahead of every entry with an equal or lower key.
               while (pos < held && $signed(key) < shadow_keys[pos])
                  pos++;
               for (int i = held; i > pos; i--) begin
                  shadow_keys[i] = shadow_keys[i-1];
                  shadow_tags[i] = shadow_tags[i-1];
               end
               shadow_keys[pos] = key;
               shadow_tags[pos] = tag;
               held++;
               if (held > peak_held)
                  peak_held = held;
            end
         end else begin
            if (held == 0) begin
               res.status = spq_pkg::STATUS_EMPTY;
               empty_pops++;
            end else begin
               res.tag = shadow_tags[0];
               res.key = shadow_keys[0];
               for (int i = 1; i < held; i++) begin
                  shadow_keys[i-1] = shadow_keys[i];
                  shadow_tags[i-1] = shadow_tags[i];
               end
               held--;
               served_pops++;
            end
         end
         res.occupancy = spq_pkg::OCC_BITS'(held);
         pending_outcomes.push_back(res);
      endfunction

      task check_response(input logic [1:0] status, input logic [15:0] tag,
                          input logic [15:0] key,
                          input logic [spq_pkg::OCC_BITS-1:0] occupancy);
         queue_outcome_type exp;
         if (pending_outcomes.size() == 0) begin
            report("response beat with no request outstanding");
         end else begin
            exp = pending_outcomes[0];
            pending_outcomes.delete(0);
            if (status !== exp.status)
               report($sformatf("status %0d, expected %0d", status, exp.status));
            if (tag !== exp.tag)
               report($sformatf("payload %h, expected %h", tag, exp.tag));
            if (key !== exp.key)
               report($sformatf("priority %h, expected %h", key, exp.key));
            if (occupancy !== exp.occupancy)
               report($sformatf("occupancy %0d, expected %0d", occupancy,
                                exp.occupancy));
         end
      endtask
   endclass

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_func         = spq_pkg::FUNC_INSERT;
   logic [15:0] req_priority_req = '0;
   logic [15:0] req_payload      = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_payload;
   logic [15:0] rsp_out_priority;
   logic [4:0]  rsp_occupancy;

   bit           idling = 1'b1;
   int           quiet_cycles = 0;
   spq_scoreboard sb = new();

   sorted_priority_queue dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_priority_req (req_priority_req),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Present one request beat and hold it until the block takes it.
   task automatic send_req(input spq_pkg::spq_func_type func, input logic [15:0] key,
                           input logic [15:0] tag);
      req_valid        <= 1'b1;
      req_func         <= func;
      req_priority_req <= key;
      req_payload      <= tag;
      do @(posedge clock); while (req_stall);
      sb.note_request(func, key, tag);
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Extremes and narrow ranges are favored so that ties happen often.
   function automatic logic [15:0] pick_key();
      case ($urandom_range(0, 5))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'($urandom_range(0, 3)) - 16'd2;
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_out_payload, rsp_out_priority, rsp_occupancy);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Watchdog expired with %0d responses outstanding", sb.outstanding());
         $display("FAIL sorted_priority_queue");
         $finish;
      end
   end

   initial begin
      @(posedge clock);
      forever begin
         if (idling && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
      end
   end

   initial begin
      int insert_pct;
      spq_pkg::spq_func_type func;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty pop, extreme keys and payloads, ties at the top, middle and bottom.
      send_req(spq_pkg::FUNC_POP,    16'h0000, 16'h0000);
      send_req(spq_pkg::FUNC_INSERT, 16'h7FFF, 16'hFFFF);
      send_req(spq_pkg::FUNC_INSERT, 16'h8000, 16'h0000);
      send_req(spq_pkg::FUNC_INSERT, 16'h0000, 16'hAAAA);
      send_req(spq_pkg::FUNC_INSERT, 16'h0000, 16'h5555);
      send_req(spq_pkg::FUNC_INSERT, 16'hFFFF, 16'h0001);
      send_req(spq_pkg::FUNC_INSERT, 16'h0001, 16'h8000);
      send_req(spq_pkg::FUNC_INSERT, 16'h7FFF, 16'h1234);
      send_req(spq_pkg::FUNC_INSERT, 16'h8000, 16'h4321);
      repeat (9) send_req(spq_pkg::FUNC_POP, 16'hFFFF, 16'hFFFF);

      // Phases alternate between filling, draining and a balanced mix.
      for (int ph = 0; ph < 8; ph++) begin
         idling = (ph != 2 && ph != 7);
         insert_pct = (ph % 3 == 0) ? 80 : (ph % 3 == 1) ? 25 : 50;
         for (int n = 0; n < 250; n++) begin
            func = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::FUNC_INSERT
                                                         : spq_pkg::FUNC_POP;
            send_req(func, pick_key(), 16'($urandom));
            if (idling && $urandom_range(0, 5) == 0)
               idle_gap($urandom_range(1, 14));
         end
         if (ph == 3) begin
            // Let the block drain completely before going on.
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.outstanding() != 0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (4) @(posedge clock);

      $display("Ran %0d requests reaching %0d of %0d entries held.",
               sb.requests, sb.peak_held, DEPTH);
      $display("%0d pops served an entry, %0d inserts hit a full queue, %0d pops hit empty.",
               sb.served_pops, sb.full_drops, sb.empty_pops);
      if (sb.errors == 0)
         $display("PASS sorted_priority_queue");
      else
         $display("FAIL sorted_priority_queue");
      $finish;
   end

endmodule
